// ===== rtl/ppkm_pkg.sv =====
package ppkm_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 24;
  localparam int END_W      = 25;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
  localparam int PROT_W     = 3;
  localparam int PKEY_W     = 4;

  // Request command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // One table entry: valid mark, protection bits, protection key
  typedef struct packed {
    logic              valid;
    logic [PROT_W-1:0] prot;
    logic [PKEY_W-1:0] pkey;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controls for the shared page stepper
  typedef struct packed {
    logic load;
    logic advance;
  } step_ctl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_WRITE,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/page_protection_key_map_top.sv =====
// Page protection key map: per-page prot/pkey table for 4 KiB pages over a window of
// 2**PAGE_INDEX_BITS pages (page number = addr[23:12], low PAGE_INDEX_BITS bits).
// After reset the table is swept clear, one entry per cycle, in ST_INIT and then ST_CLEAR,
// during which in_stall stays high; cfg writes are taken at any time.
// One request is handled at a time through the single table RAM port and one shared
// page stepper: a lookup passes through ST_READ and ST_RESP before the next request
// can be accepted (result registered, held on out_stall); an update writes each page covered
// in ST_WRITE after ST_PREP, ending at ST_PREP if the range is empty or the map is disabled.
// Updates produce no result; every lookup produces exactly one.
module page_protection_key_map_top #(
  parameter int PAGE_INDEX_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  // requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [ppkm_pkg::ADDR_W-1:0]     addr,
  input  logic [ppkm_pkg::END_W-1:0]      end_addr,
  input  logic [ppkm_pkg::PROT_W-1:0]     prot,
  input  logic [ppkm_pkg::PKEY_W-1:0]     pkey,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [ppkm_pkg::PROT_W-1:0]     prot_out,
  output logic [ppkm_pkg::PKEY_W-1:0]     pkey_out
);

  localparam int DEPTH = 1 << PAGE_INDEX_BITS;
  localparam int CNT_W = (PAGE_INDEX_BITS > ppkm_pkg::PAGE_NUM_W) ? PAGE_INDEX_BITS
                                                                  : ppkm_pkg::PAGE_NUM_W;

  logic                          map_enabled;
  ppkm_pkg::step_ctl_t           step_ctl;
  logic [CNT_W-1:0]              step_start;
  logic [CNT_W-1:0]              step_last;
  logic [CNT_W-1:0]              step_cnt;
  logic                          step_at_last;
  logic                          ram_we;
  logic [PAGE_INDEX_BITS-1:0]    ram_addr;
  ppkm_pkg::entry_t              ram_wdata;
  ppkm_pkg::entry_t              ram_rdata;
  logic [ppkm_pkg::ENTRY_W-1:0]  ram_rdata_raw;

  // Enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      map_enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      map_enabled <= cfg_wr_data;
    end
  end

  assign ram_rdata = ram_rdata_raw;

  ppkm_ctrl #(
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
    .CNT_W           (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .map_enabled  (map_enabled),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .addr         (addr),
    .end_addr     (end_addr),
    .prot         (prot),
    .pkey         (pkey),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .prot_out     (prot_out),
    .pkey_out     (pkey_out),
    .step_ctl     (step_ctl),
    .step_start   (step_start),
    .step_last    (step_last),
    .step_cnt     (step_cnt),
    .step_at_last (step_at_last),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .ram_rdata    (ram_rdata)
  );

  ppkm_step #(
    .CNT_W (CNT_W)
  ) u_step (
    .clk       (clk),
    .ctl       (step_ctl),
    .start_val (step_start),
    .last_val  (step_last),
    .cnt       (step_cnt),
    .at_last   (step_at_last)
  );

  ppkm_ram #(
    .WIDTH (ppkm_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata_raw)
  );

endmodule

// ===== rtl/ppkm_ram.sv =====
module ppkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ppkm_step.sv =====
module ppkm_step #(
  parameter int CNT_W = 12
) (
  input  logic                clk,
  input  ppkm_pkg::step_ctl_t ctl,
  input  logic [CNT_W-1:0]    start_val,
  input  logic [CNT_W-1:0]    last_val,
  output logic [CNT_W-1:0]    cnt,
  output logic                at_last
);

  logic [CNT_W-1:0] last;

  // Counter with end bound, loaded per sweep
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cnt  <= start_val;
      last <= last_val;
    end else if (ctl.advance) begin
      cnt  <= cnt + CNT_W'(1);
    end
  end

  assign at_last = (cnt == last);

endmodule

// ===== rtl/ppkm_ctrl.sv =====
module ppkm_ctrl #(
  parameter int PAGE_INDEX_BITS = 12,
  parameter int CNT_W           = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            map_enabled,
  // request side
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [ppkm_pkg::ADDR_W-1:0]     addr,
  input  logic [ppkm_pkg::END_W-1:0]      end_addr,
  input  logic [ppkm_pkg::PROT_W-1:0]     prot,
  input  logic [ppkm_pkg::PKEY_W-1:0]     pkey,
  // result side
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [ppkm_pkg::PROT_W-1:0]     prot_out,
  output logic [ppkm_pkg::PKEY_W-1:0]     pkey_out,
  // page stepper
  output ppkm_pkg::step_ctl_t             step_ctl,
  output logic [CNT_W-1:0]                step_start,
  output logic [CNT_W-1:0]                step_last,
  input  logic [CNT_W-1:0]                step_cnt,
  input  logic                            step_at_last,
  // table RAM
  output logic                            ram_we,
  output logic [PAGE_INDEX_BITS-1:0]      ram_addr,
  output ppkm_pkg::entry_t                ram_wdata,
  input  ppkm_pkg::entry_t                ram_rdata
);

  ppkm_pkg::state_t state, state_next;

  logic                          cmd_q;
  logic [ppkm_pkg::ADDR_W-1:0]   addr_q;
  logic [ppkm_pkg::END_W-1:0]    end_q;
  ppkm_pkg::entry_t              entry_q;

  logic                          accept;
  logic                          range_empty;
  logic [ppkm_pkg::END_W-1:0]    end_m1;
  logic [CNT_W-1:0]              first_page;
  logic [CNT_W-1:0]              last_page;
  logic [CNT_W-1:0]              clr_last;
  logic                          resp_load;
  logic                          hit;

  assign accept = in_valid && !in_stall;

  // Page numbers of the latched request
  assign range_empty = (end_q <= {1'b0, addr_q});
  assign end_m1      = end_q - ppkm_pkg::END_W'(1);
  assign first_page  = CNT_W'(addr_q[ppkm_pkg::ADDR_W-1:ppkm_pkg::PAGE_SHIFT]);
  assign last_page   = CNT_W'(end_m1[ppkm_pkg::ADDR_W-1:ppkm_pkg::PAGE_SHIFT]);

  always_comb begin
    clr_last = '0;
    clr_last[PAGE_INDEX_BITS-1:0] = '1;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppkm_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath controls
  always_comb begin
    state_next       = state;
    in_stall         = 1'b1;
    step_ctl.load    = 1'b0;
    step_ctl.advance = 1'b0;
    step_start       = first_page;
    step_last        = last_page;
    ram_we           = 1'b0;
    ram_addr         = first_page[PAGE_INDEX_BITS-1:0];
    ram_wdata        = entry_q;
    resp_load        = 1'b0;
    unique case (state)
      ppkm_pkg::ST_INIT: begin
        step_ctl.load = 1'b1;
        step_start    = '0;
        step_last     = clr_last;
        state_next    = ppkm_pkg::ST_CLEAR;
      end
      ppkm_pkg::ST_CLEAR: begin
        ram_we           = 1'b1;
        ram_addr         = step_cnt[PAGE_INDEX_BITS-1:0];
        ram_wdata        = '0;
        step_ctl.advance = 1'b1;
        if (step_at_last) begin
          state_next = ppkm_pkg::ST_IDLE;
        end
      end
      ppkm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (cmd == ppkm_pkg::CMD_LOOKUP) ? ppkm_pkg::ST_READ
                                                     : ppkm_pkg::ST_PREP;
        end
      end
      ppkm_pkg::ST_PREP: begin
        if (!map_enabled || range_empty) begin
          state_next = ppkm_pkg::ST_IDLE;
        end else begin
          step_ctl.load = 1'b1;
          state_next    = ppkm_pkg::ST_WRITE;
        end
      end
      ppkm_pkg::ST_WRITE: begin
        ram_we           = 1'b1;
        ram_addr         = step_cnt[PAGE_INDEX_BITS-1:0];
        step_ctl.advance = 1'b1;
        if (step_at_last) begin
          state_next = ppkm_pkg::ST_IDLE;
        end
      end
      ppkm_pkg::ST_READ: begin
        state_next = ppkm_pkg::ST_RESP;
      end
      ppkm_pkg::ST_RESP: begin
        if (!out_valid || !out_stall) begin
          resp_load  = 1'b1;
          state_next = ppkm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppkm_pkg::ST_INIT;
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q         <= cmd;
      addr_q        <= addr;
      end_q         <= end_addr;
      entry_q.valid <= 1'b1;
      entry_q.prot  <= prot;
      entry_q.pkey  <= pkey;
    end
  end

  // Lookup result; a disabled map always misses
  assign hit = map_enabled && ram_rdata.valid && (cmd_q == ppkm_pkg::CMD_LOOKUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      found    <= hit;
      prot_out <= hit ? ram_rdata.prot : '0;
      pkey_out <= hit ? ram_rdata.pkey : '0;
    end
  end

  // Checks
  a_rose_after_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ppkm_pkg::ST_RESP)
    else $error("result appeared without a lookup response");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> prot_out == '0 && pkey_out == '0)
    else $error("miss carries nonzero fields");

  a_write_runs_to_end: assert property (@(posedge clk) disable iff (rst)
    state == ppkm_pkg::ST_WRITE && !step_at_last |=> state == ppkm_pkg::ST_WRITE)
    else $error("page write loop left early");

  a_resp_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ppkm_pkg::ST_RESP && state_next == ppkm_pkg::ST_IDLE |=> out_valid)
    else $error("lookup response not registered");

endmodule
